// File: src/wind_sway_spring_step_assert.svh
// Assertion macros used by the wind sway RTL.
`ifndef WIND_SWAY_SPRING_STEP_ASSERT_SVH
`define WIND_SWAY_SPRING_STEP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define WSS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wind sway assertion failed");

// Next-cycle implication.
`define WSS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wind sway assertion failed");

`endif

// File: src/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// Types, constants and helper functions of the wind sway spring step block.
// ----------------------------------------------------------------------------
`default_nettype none

package wss_pkg;

   localparam int SLOTS     = 1024;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int TAB_DEPTH = 64;
   localparam int TAB_W     = $clog2(TAB_DEPTH);
   localparam int QW        = 48;

   localparam logic signed [31:0] Q_ONE     = 32'sd65536;
   localparam logic signed [31:0] Q_NEG_ONE = -32'sd65536;
   localparam logic signed [31:0] K_HALF    = 32'sd32768;
   localparam logic signed [31:0] K_HUNDRED = 32'sd6553600;
   localparam logic signed [31:0] K_DT      = 32'sd1088;
   localparam logic [21:0]        GAIN_RST  = 22'd65536;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_PROC = 1'b1;

   localparam logic [1:0] CSR_PHASE  = 2'd0;
   localparam logic [1:0] CSR_FREEZE = 2'd1;
   localparam logic [1:0] CSR_GAIN   = 2'd2;

   typedef struct packed {
      logic              command;
      logic [9:0]        slot;
      logic signed [31:0] stiffness;
      logic signed [31:0] row0_x;
      logic signed [31:0] row0_y;
      logic signed [31:0] row0_z;
      logic signed [31:0] row1_x;
      logic signed [31:0] row1_y;
      logic signed [31:0] row1_z;
      logic signed [31:0] row2_x;
      logic signed [31:0] row2_y;
      logic signed [31:0] row2_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out0_x;
      logic signed [31:0] out0_z;
      logic signed [31:0] out1_x;
      logic signed [31:0] out1_z;
      logic signed [31:0] out2_x;
      logic signed [31:0] out2_z;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [31:0] wdata;
   } csr_type;

   typedef struct packed {
      logic signed [31:0] sway_x;
      logic signed [31:0] sway_z;
      logic signed [31:0] drift_x;
      logic signed [31:0] drift_z;
   } spring_type;

   typedef struct packed {
      logic signed [31:0] fx;
      logic signed [31:0] fz;
   } force_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] clamp_one(input logic signed [31:0] v);
      logic signed [31:0] r;
      if (v > Q_ONE) begin
         r = Q_ONE;
      end else if (v < Q_NEG_ONE) begin
         r = Q_NEG_ONE;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: src/wss_if.sv
// ----------------------------------------------------------------------------
// wss interfaces
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface wss_req_if import wss_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface wss_rsp_if import wss_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface wss_csr_if import wss_pkg::*; ();
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/wind_sway_spring_step.sv
// ----------------------------------------------------------------------------
// wind_sway_spring_step
// Per-instance wind sway: damped spring step on x and z, matrix row offsets.
//
// Channel  Dir  Payload                                      Transfer
// req      in   command, slot, stiffness, rows 0..2 x/y/z    valid & ready
// rsp      out  out0_x .. out2_z                             valid & ready
// csr      in   index (0 phase, 1 freeze, 2 gain), wdata     valid & ready
//
// A load is written at its transfer. A process item runs through its steps from its
// transfer to the result register; its 17 products share the one multiplier.
// After reset the spring memory is cleared slot by slot; req stays low until done.
// A pending result does not block a new request, only the final result write.
// ----------------------------------------------------------------------------
`default_nettype none
`include "wind_sway_spring_step_assert.svh"

module wind_sway_spring_step import wss_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   wss_req_if.sink   req,
   wss_rsp_if.source rsp,
   wss_csr_if.sink   csr
);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   localparam logic [4:0] S_K     = 5'd0;
   localparam logic [4:0] S_KUSE  = 5'd1;
   localparam logic [4:0] S_HALF  = 5'd2;
   localparam logic [4:0] S_HUND  = 5'd3;
   localparam logic [4:0] S_FORCE = 5'd4;
   localparam logic [4:0] S_FDT   = 5'd5;
   localparam logic [4:0] S_DRIFT = 5'd6;
   localparam logic [4:0] S_DDT   = 5'd7;
   localparam logic [4:0] S_SWAY  = 5'd8;
   localparam logic [4:0] S_VEL   = 5'd9;
   localparam logic [4:0] S_VUSE  = 5'd10;
   localparam logic [4:0] S_O0X   = 5'd11;
   localparam logic [4:0] S_O0Z   = 5'd12;
   localparam logic [4:0] S_O1X   = 5'd13;
   localparam logic [4:0] S_O1Z   = 5'd14;
   localparam logic [4:0] S_O2X   = 5'd15;
   localparam logic [4:0] S_O2Z   = 5'd16;
   localparam logic [4:0] S_LAST  = 5'd17;

   state_type          state_ff, state_in;
   logic [4:0]         step_ff, step_in;
   logic               ax_ff, ax_in;
   req_type            in_ff, in_in;
   logic signed [31:0] k_ff, k_in;
   logic signed [QW-1:0] acc_ff, acc_in;
   logic signed [31:0] f_ff, f_in;
   logic signed [31:0] dx_ff, dx_in, dz_ff, dz_in;
   logic signed [31:0] vx_ff, vx_in, vz_ff, vz_in;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TAB_W-1:0]   phase_ff, phase_in;
   logic               freeze_ff, freeze_in;
   logic [21:0]        gain_ff, gain_in;

   logic               req_fire, csr_fire, out_free, clr_busy;
   logic               mul_en;
   logic signed [31:0] mul_a, mul_b;
   logic signed [QW-1:0] p;
   logic signed [63:0] p64;
   logic signed [31:0] sway_cur, drift_cur, force_cur, tmp;
   logic               mem_we;
   spring_type         sp_rd, sp_wr;
   force_type          frc_rd;

   assign req_fire  = req.valid && req.ready;
   assign csr_fire  = csr.valid && csr.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && !clr_busy;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;
   assign p64       = 64'(p);

   assign sway_cur  = ax_ff ? sp_rd.sway_z  : sp_rd.sway_x;
   assign drift_cur = ax_ff ? sp_rd.drift_z : sp_rd.drift_x;
   assign force_cur = ax_ff ? frc_rd.fz     : frc_rd.fx;

   wss_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .p     (p)
   );

   assign mem_we = (state_ff == ST_RUN) && (step_ff == S_LAST) && out_free && !freeze_ff;
   assign sp_wr  = '{sway_x: vx_ff, sway_z: vz_ff, drift_x: dx_ff, drift_z: dz_ff};

   wss_spring_mem u_spring (
      .clock (clock),
      .reset (reset),
      .we    (mem_we),
      .waddr (in_ff.slot[SLOT_W-1:0]),
      .wdata (sp_wr),
      .re    (req_fire && req.data.command == CMD_PROC),
      .raddr (req.data.slot[SLOT_W-1:0]),
      .rdata (sp_rd),
      .busy  (clr_busy)
   );

   wss_force_tab u_force (
      .clock (clock),
      .reset (reset),
      .we    (req_fire && req.data.command == CMD_LOAD),
      .waddr (req.data.slot[TAB_W-1:0]),
      .wdata (force_type'{fx: req.data.row0_x, fz: req.data.row0_z}),
      .re    (req_fire && req.data.command == CMD_PROC),
      .raddr (phase_ff + req.data.slot[TAB_W-1:0]),
      .rdata (frc_rd)
   );

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_en = 1'b0;
      mul_a  = '0;
      mul_b  = '0;
      if (state_ff == ST_RUN) begin
         case (step_ff)
            S_K: begin
               mul_en = 1'b1; mul_a = in_ff.stiffness; mul_b = 32'({10'b0, gain_ff});
            end
            S_HALF: begin
               mul_en = 1'b1; mul_a = K_HALF; mul_b = drift_cur;
            end
            S_HUND: begin
               mul_en = 1'b1; mul_a = K_HUNDRED; mul_b = sway_cur;
            end
            S_FDT: begin
               mul_en = 1'b1; mul_a = f_ff; mul_b = K_DT;
            end
            S_DDT: begin
               mul_en = 1'b1; mul_a = ax_ff ? dz_ff : dx_ff; mul_b = K_DT;
            end
            S_VEL: begin
               mul_en = 1'b1; mul_a = f_ff; mul_b = k_ff;
            end
            S_O0X: begin
               mul_en = 1'b1; mul_a = vx_ff; mul_b = in_ff.row0_y;
            end
            S_O0Z: begin
               mul_en = 1'b1; mul_a = vz_ff; mul_b = in_ff.row0_y;
            end
            S_O1X: begin
               mul_en = 1'b1; mul_a = vx_ff; mul_b = in_ff.row1_y;
            end
            S_O1Z: begin
               mul_en = 1'b1; mul_a = vz_ff; mul_b = in_ff.row1_y;
            end
            S_O2X: begin
               mul_en = 1'b1; mul_a = vx_ff; mul_b = in_ff.row2_y;
            end
            S_O2Z: begin
               mul_en = 1'b1; mul_a = vz_ff; mul_b = in_ff.row2_y;
            end
            default: begin
               mul_en = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      ax_in        = ax_ff;
      in_in        = in_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      f_in         = f_ff;
      dx_in        = dx_ff;
      dz_in        = dz_ff;
      vx_in        = vx_ff;
      vz_in        = vz_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      phase_in     = phase_ff;
      freeze_in    = freeze_ff;
      gain_in      = gain_ff;
      tmp          = '0;

      if (csr_fire) begin
         case (csr.data.index)
            CSR_PHASE:  phase_in  = csr.data.wdata[TAB_W-1:0];
            CSR_FREEZE: freeze_in = csr.data.wdata[0];
            CSR_GAIN:   gain_in   = csr.data.wdata[21:0];
            default:    phase_in  = phase_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req.data.command == CMD_PROC) begin
               in_in    = req.data;
               state_in = ST_RUN;
               step_in  = S_K;
               ax_in    = 1'b0;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 5'd1;
            case (step_ff)
               S_KUSE:  k_in   = sat32(p64);
               S_HUND:  acc_in = p;
               S_FORCE: f_in   = sat32(64'(force_cur) - (64'(acc_ff) + p64));
               S_DRIFT: begin
                  tmp = sat32(64'(drift_cur) + p64);
                  if (ax_ff) dz_in = tmp; else dx_in = tmp;
               end
               S_SWAY:  f_in = clamp_one(sat32(64'(sway_cur) + p64));
               S_VUSE: begin
                  tmp = sat32(p64);
                  if (ax_ff) begin
                     vz_in = tmp;
                  end else begin
                     vx_in   = tmp;
                     ax_in   = 1'b1;
                     step_in = S_HALF;
                  end
               end
               S_O0Z: res_in.out0_x = sat32(64'(in_ff.row0_x) + p64);
               S_O1X: res_in.out0_z = sat32(64'(in_ff.row0_z) + p64);
               S_O1Z: res_in.out1_x = sat32(64'(in_ff.row1_x) + p64);
               S_O2X: res_in.out1_z = sat32(64'(in_ff.row1_z) + p64);
               S_O2Z: res_in.out2_x = sat32(64'(in_ff.row2_x) + p64);
               S_LAST: begin
                  step_in = S_LAST;
                  if (out_free) begin
                     rsp_data_in        = res_ff;
                     rsp_data_in.out2_z = sat32(64'(in_ff.row2_z) + p64);
                     rsp_valid_in       = 1'b1;
                     state_in           = ST_IDLE;
                  end
               end
               default: tmp = '0;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= S_K;
         ax_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
         freeze_ff    <= 1'b0;
         gain_ff      <= GAIN_RST;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         ax_ff        <= ax_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         freeze_ff    <= freeze_in;
         gain_ff      <= gain_in;
      end
      in_ff       <= in_in;
      k_ff        <= k_in;
      acc_ff      <= acc_in;
      f_ff        <= f_in;
      dx_ff       <= dx_in;
      dz_ff       <= dz_in;
      vx_ff       <= vx_in;
      vz_ff       <= vz_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   `WSS_ASSERT_NOW(a_no_req_while_clearing, clr_busy, !req.ready)
   `WSS_ASSERT_NEXT(a_proc_starts_run, req_fire && req.data.command == CMD_PROC,
                    state_ff == ST_RUN && step_ff == S_K)
   `WSS_ASSERT_NEXT(a_finish_sets_result, state_ff == ST_RUN && step_ff == S_LAST && out_free,
                    rsp.valid && state_ff == ST_IDLE)
   `WSS_ASSERT_NOW(a_writeback_only_at_end, mem_we, state_ff == ST_RUN && ax_ff)

endmodule

`default_nettype wire

// File: src/wss_mul.sv
// ----------------------------------------------------------------------------
// wss_mul
// Shared Q16.16 multiplier: full product, round half up, registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module wss_mul import wss_pkg::*; (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [31:0] a,
   input  wire logic signed [31:0] b,
   output logic signed [QW-1:0]    p
);

   logic signed [63:0]   prod;
   logic signed [63:0]   rnd;
   logic signed [QW-1:0] p_ff;
   logic signed [QW-1:0] p_in;

   always_comb begin
      prod = a * b;
      rnd  = prod + 64'sd32768;
      // Taking the upper bits is an arithmetic shift right by 16.
      p_in = en ? rnd[63:16] : p_ff;
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

`default_nettype wire

// File: src/wss_spring_mem.sv
// ----------------------------------------------------------------------------
// wss_spring_mem
// Per-slot spring state memory with a clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module wss_spring_mem import wss_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              we,
   input  wire logic [SLOT_W-1:0] waddr,
   input  wire spring_type        wdata,
   input  wire logic              re,
   input  wire logic [SLOT_W-1:0] raddr,
   output spring_type             rdata,
   output logic                   busy
);

   spring_type        mem_ff [SLOTS];
   spring_type        rdata_ff;
   logic [SLOT_W:0]   clr_ff;
   logic [SLOT_W:0]   clr_in;
   logic              busy_ff;
   logic              busy_in;

   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in  = clr_ff + 1'b1;
         busy_in = (clr_ff != (SLOT_W+1)'(SLOTS - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_ff  <= clr_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem_ff[clr_ff[SLOT_W-1:0]] <= '0;
      end else if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
   assign busy  = busy_ff;

endmodule

`default_nettype wire

// File: src/wss_force_tab.sv
// ----------------------------------------------------------------------------
// wss_force_tab
// Wind force table; entries never loaded read as 1.0 on both axes.
// ----------------------------------------------------------------------------
`default_nettype none

module wss_force_tab import wss_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             we,
   input  wire logic [TAB_W-1:0] waddr,
   input  wire force_type        wdata,
   input  wire logic             re,
   input  wire logic [TAB_W-1:0] raddr,
   output force_type             rdata
);

   force_type              mem_ff [TAB_DEPTH];
   force_type              rdata_ff;
   logic [TAB_DEPTH-1:0]   valid_ff;
   logic [TAB_DEPTH-1:0]   valid_in;
   logic                   rvalid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (we) begin
         valid_in[waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff  <= mem_ff[raddr];
         rvalid_ff <= valid_ff[raddr];
      end
   end

   assign rdata = rvalid_ff ? rdata_ff : force_type'{fx: Q_ONE, fz: Q_ONE};

endmodule

`default_nettype wire
